FILE: sv/three_axis_joystick_velocity_top_defines.svh
// Assertion macros shared by the pedal velocity block
`ifndef THREE_AXIS_JOYSTICK_VELOCITY_TOP_DEFINES_SVH
`define THREE_AXIS_JOYSTICK_VELOCITY_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TAJV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define TAJV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tajv_pkg.sv
// Types, constants and register codes of the pedal velocity block
`default_nettype none
package tajv_pkg;

  localparam int RawW  = 16;
  localparam int PosW  = 32;
  localparam int VelW  = 32;
  localparam int VpcW  = 32;
  localparam int GainW = 24;
  localparam int OpAW  = PosW + 1;
  localparam int ProdW = 58;
  localparam int FracW = 16;
  localparam int IdxW  = 3;
  localparam int DataW = 32;

  localparam logic [RawW-1:0] OffsetReset = 16'd35000;

  localparam logic signed [VelW-1:0] VelMax = 32'sh7FFF_FFFF;
  localparam logic signed [VelW-1:0] VelMin = 32'sh8000_0000;

  localparam logic signed [PosW-1:0] WallXLo = -32'sd39321;
  localparam logic signed [PosW-1:0] WallXHi = 32'sd0;
  localparam logic signed [PosW-1:0] WallYLo = -32'sd26214;
  localparam logic signed [PosW-1:0] WallYHi = 32'sd26214;
  localparam logic signed [PosW-1:0] WallZLo = 32'sd22938;
  localparam logic signed [PosW-1:0] WallZHi = 32'sd45875;

  typedef enum logic [IdxW-1:0] {
    REG_CONTROL_MODE       = 3'd0,
    REG_ADC_ZERO_OFFSET    = 3'd1,
    REG_PRESS_THRESHOLD    = 3'd2,
    REG_VELOCITY_PER_COUNT = 3'd3,
    REG_CONVERGENCE_GAIN   = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    SEL_PLUS  = 2'd0,
    SEL_MINUS = 2'd1,
    SEL_TRACK = 2'd2
  } sel_t;

  typedef struct packed {
    logic             control_mode;
    logic [RawW-1:0]  adc_zero_offset;
    logic [RawW-1:0]  press_threshold;
    logic [VpcW-1:0]  velocity_per_count;
    logic [GainW-1:0] convergence_gain;
  } cfg_t;

  typedef struct packed {
    logic ld1;
    logic accept;
    logic ld2;
    logic pose_seen;
  } lane_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/tajv_cfg.sv
// Configuration register file of the pedal velocity block
`default_nettype none
module tajv_cfg (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [tajv_pkg::IdxW-1:0]  cfg_index,
  input  wire logic [tajv_pkg::DataW-1:0] cfg_data,
  output tajv_pkg::cfg_t                cfg
);
  import tajv_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_mode       <= 1'b0;
      cfg.adc_zero_offset    <= OffsetReset;
      cfg.press_threshold    <= '0;
      cfg.velocity_per_count <= '0;
      cfg.convergence_gain   <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CONTROL_MODE:       cfg.control_mode       <= cfg_data[0];
        REG_ADC_ZERO_OFFSET:    cfg.adc_zero_offset    <= cfg_data[RawW-1:0];
        REG_PRESS_THRESHOLD:    cfg.press_threshold    <= cfg_data[RawW-1:0];
        REG_VELOCITY_PER_COUNT: cfg.velocity_per_count <= cfg_data[VpcW-1:0];
        REG_CONVERGENCE_GAIN:   cfg.convergence_gain   <= cfg_data[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/tajv_lane.sv
// One axis lane: press decode, target hold, multiply, saturate and wall
`default_nettype none
module tajv_lane (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tajv_pkg::lane_ctrl_t            ctrl,
  input  wire tajv_pkg::cfg_t                  cfg,
  input  wire logic [tajv_pkg::RawW-1:0]       raw_plus,
  input  wire logic [tajv_pkg::RawW-1:0]       raw_minus,
  input  wire logic signed [tajv_pkg::PosW-1:0] pos,
  input  wire logic signed [tajv_pkg::PosW-1:0] wall_lo,
  input  wire logic signed [tajv_pkg::PosW-1:0] wall_hi,
  output logic signed [tajv_pkg::VelW-1:0]     vel
);
  import tajv_pkg::*;

  logic signed [PosW-1:0]   target;
  logic signed [PosW-1:0]   tgt_eff;
  logic signed [RawW:0]     press_p;
  logic signed [RawW:0]     press_m;
  logic                     hit_p;
  logic                     hit_m;
  logic signed [OpAW-1:0]   diff;
  sel_t                     sel;
  logic signed [OpAW-1:0]   op_a;
  logic [VpcW-1:0]          op_b;

  sel_t                     s1_sel;
  logic signed [OpAW-1:0]   s1_a;
  logic [VpcW-1:0]          s1_b;
  logic signed [PosW-1:0]   s1_pos;

  logic signed [2*OpAW-1:0] full_prod;
  sel_t                     s2_sel;
  logic signed [ProdW-1:0]  s2_prod;
  logic signed [PosW-1:0]   s2_pos;

  logic [VelW-1:0]          mag;
  logic signed [ProdW-1:0]  biased;
  logic signed [ProdW-FracW-1:0] trunc;
  logic signed [VelW-1:0]   vel_sat;

  always_comb begin
    press_p = $signed({1'b0, cfg.adc_zero_offset}) - $signed({1'b0, raw_plus});
    press_m = $signed({1'b0, cfg.adc_zero_offset}) - $signed({1'b0, raw_minus});
    hit_p   = press_p > $signed({1'b0, cfg.press_threshold});
    hit_m   = press_m > $signed({1'b0, cfg.press_threshold});
    tgt_eff = ctrl.pose_seen ? target : pos;
    diff    = $signed({tgt_eff[PosW-1], tgt_eff}) - $signed({pos[PosW-1], pos});
    if (hit_p) begin
      sel  = SEL_PLUS;
      op_a = $signed({{(OpAW-RawW){1'b0}}, press_p[RawW-1:0]});
      op_b = cfg.velocity_per_count;
    end else if (hit_m) begin
      sel  = SEL_MINUS;
      op_a = $signed({{(OpAW-RawW){1'b0}}, press_m[RawW-1:0]});
      op_b = cfg.velocity_per_count;
    end else begin
      sel  = SEL_TRACK;
      op_a = diff;
      op_b = {{(VpcW-GainW){1'b0}}, cfg.convergence_gain};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (ctrl.accept) begin
      if (cfg.control_mode && (hit_p || hit_m)) begin
        target <= pos;
      end else if (!ctrl.pose_seen) begin
        target <= pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      s1_sel <= sel;
      s1_a   <= op_a;
      s1_b   <= op_b;
      s1_pos <= pos;
    end
  end

  assign full_prod = s1_a * $signed({1'b0, s1_b});

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      s2_sel  <= s1_sel;
      s2_prod <= full_prod[ProdW-1:0];
      s2_pos  <= s1_pos;
    end
  end

  always_comb begin
    mag    = s2_prod[FracW+VelW-1:FracW];
    biased = s2_prod + $signed({{(ProdW-FracW){1'b0}},
                                {FracW{s2_prod[ProdW-1]}}});
    trunc  = biased[ProdW-1:FracW];
    unique case (s2_sel)
      SEL_PLUS:  vel_sat = mag[VelW-1] ? VelMax : $signed(mag);
      SEL_MINUS: vel_sat = mag[VelW-1] ? VelMin : $signed(VelW'(0) - mag);
      SEL_TRACK: begin
        if (trunc[ProdW-FracW-1] && !(&trunc[ProdW-FracW-2:VelW-1])) begin
          vel_sat = VelMin;
        end else if (!trunc[ProdW-FracW-1] && (|trunc[ProdW-FracW-2:VelW-1])) begin
          vel_sat = VelMax;
        end else begin
          vel_sat = trunc[VelW-1:0];
        end
      end
      default: vel_sat = '0;
    endcase
    if ((s2_pos < wall_lo && vel_sat < 0) || (s2_pos > wall_hi && vel_sat > 0)) begin
      vel = '0;
    end else begin
      vel = vel_sat;
    end
  end

endmodule
`default_nettype wire

FILE: sv/three_axis_joystick_velocity_top.sv
// Top level of the three-axis pedal velocity block
//
//   channel  | signals                                | direction
//   ---------+----------------------------------------+----------
//   input    | in_valid, in_stall, raw_*, pos_*       | item in
//   output   | out_valid, out_stall, vel_x/y/z        | item out
//   config   | cfg_we, cfg_index, cfg_data            | write only
//
// One item per cycle while out_stall is low; an accepted item passes the s1, s2 and output registers.
// Three lanes each decode, latch the target, multiply, then saturate and wall.
// Reset loads config defaults, clears targets and all valid bits; the first item loads targets.
// Bubbles collapse: an empty stage loads even while a result is held by out_stall.
`default_nettype none
`include "three_axis_joystick_velocity_top_defines.svh"
module three_axis_joystick_velocity_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [tajv_pkg::RawW-1:0]         raw_x_plus,
  input  wire logic [tajv_pkg::RawW-1:0]         raw_x_minus,
  input  wire logic [tajv_pkg::RawW-1:0]         raw_y_plus,
  input  wire logic [tajv_pkg::RawW-1:0]         raw_y_minus,
  input  wire logic [tajv_pkg::RawW-1:0]         raw_z_plus,
  input  wire logic [tajv_pkg::RawW-1:0]         raw_z_minus,
  input  wire logic signed [tajv_pkg::PosW-1:0]  pos_x,
  input  wire logic signed [tajv_pkg::PosW-1:0]  pos_y,
  input  wire logic signed [tajv_pkg::PosW-1:0]  pos_z,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [tajv_pkg::VelW-1:0]       vel_x,
  output logic signed [tajv_pkg::VelW-1:0]       vel_y,
  output logic signed [tajv_pkg::VelW-1:0]       vel_z,
  input  wire logic                              cfg_we,
  input  wire logic [tajv_pkg::IdxW-1:0]         cfg_index,
  input  wire logic [tajv_pkg::DataW-1:0]        cfg_data
);
  import tajv_pkg::*;

  cfg_t                   cfg;
  lane_ctrl_t             ctrl;
  logic                   v1;
  logic                   v2;
  logic                   pose_seen;
  logic                   ld_out;
  logic                   ld2;
  logic                   ld1;
  logic                   accept;
  logic signed [VelW-1:0] lane_x;
  logic signed [VelW-1:0] lane_y;
  logic signed [VelW-1:0] lane_z;

  always_comb begin
    ld_out   = !out_valid || !out_stall;
    ld2      = !v2 || ld_out;
    ld1      = !v1 || ld2;
    accept   = in_valid && ld1;
    in_stall = !ld1;
    ctrl.ld1       = ld1;
    ctrl.accept    = accept;
    ctrl.ld2       = ld2;
    ctrl.pose_seen = pose_seen;
  end

  tajv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tajv_lane u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .raw_plus  (raw_x_plus),
    .raw_minus (raw_x_minus),
    .pos       (pos_x),
    .wall_lo   (WallXLo),
    .wall_hi   (WallXHi),
    .vel       (lane_x)
  );

  tajv_lane u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .raw_plus  (raw_y_plus),
    .raw_minus (raw_y_minus),
    .pos       (pos_y),
    .wall_lo   (WallYLo),
    .wall_hi   (WallYHi),
    .vel       (lane_y)
  );

  tajv_lane u_lane_z (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .raw_plus  (raw_z_plus),
    .raw_minus (raw_z_minus),
    .pos       (pos_z),
    .wall_lo   (WallZLo),
    .wall_hi   (WallZHi),
    .vel       (lane_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
      pose_seen <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= in_valid;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (ld_out) begin
        out_valid <= v2;
      end
      if (accept) begin
        pose_seen <= 1'b1;
      end
    end
  end

  // merge lanes; off mode forces zero
  always_ff @(posedge clk) begin
    if (ld_out) begin
      vel_x <= cfg.control_mode ? lane_x : '0;
      vel_y <= cfg.control_mode ? lane_y : '0;
      vel_z <= cfg.control_mode ? lane_z : '0;
    end
  end

  `TAJV_ASSERT_NOW(a_stall_needs_item, in_stall, v1, "input stalled with empty first stage")
  `TAJV_ASSERT_NOW(a_stall_full_pipe, in_stall, v2 && out_valid && out_stall, "input stalled with room in pipeline")
  `TAJV_ASSERT_NEXT(a_pose_after_accept, accept, pose_seen, "pose flag not set after an item")

endmodule
`default_nettype wire

FILE: tb/three_axis_joystick_velocity_top_tb.sv
// Self-checking testbench for the three-axis pedal velocity block
`timescale 1ns / 1ps
module three_axis_joystick_velocity_top_tb;
  import tajv_pkg::*;

  localparam int AxisX = 0;
  localparam int AxisY = 1;
  localparam int AxisZ = 2;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 40;
  localparam int RandomPhases = 9;
  localparam int PhaseItems   = 100;
  localparam int IdlePct      = 31;

  localparam int SpareIdxFirst = 5;
  localparam int SpareIdxLast  = 7;

  localparam bit [RawW-1:0] RestOffset = 16'd35000;
  localparam longint VelTop    = 64'sd2147483647;
  localparam longint VelBottom = -64'sd2147483648;
  localparam int PosMin = 32'sh8000_0000;
  localparam int PosMax = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [2:0][RawW-1:0] raw_plus;
    logic [2:0][RawW-1:0] raw_minus;
    logic [2:0][PosW-1:0] pos;
  } pedal_item_t;

  typedef logic [2:0][VelW-1:0] vel_set_t;

  class velocity_ledger;
    bit             mode;
    bit [RawW-1:0]  offset;
    bit [RawW-1:0]  thr;
    bit [VpcW-1:0]  vpc;
    bit [GainW-1:0] gain;
    longint         target [3];
    bit             pose_seen;
    vel_set_t       due_vel [$];
    int             errors;
    string          axis_tag;

    function new();
      mode      = 1'b0;
      offset    = RestOffset;
      thr       = '0;
      vpc       = '0;
      gain      = '0;
      target    = '{0, 0, 0};
      pose_seen = 1'b0;
      errors    = 0;
      axis_tag  = "xyz";
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [DataW-1:0] data);
      case (idx)
        REG_CONTROL_MODE:       mode = data[0];
        REG_ADC_ZERO_OFFSET:    offset = data[RawW-1:0];
        REG_PRESS_THRESHOLD:    thr = data[RawW-1:0];
        REG_VELOCITY_PER_COUNT: vpc = data[VpcW-1:0];
        REG_CONVERGENCE_GAIN:   gain = data[GainW-1:0];
        default: ;
      endcase
    endfunction

    function longint wall_lo(int a);
      case (a)
        AxisX:   return -64'sd39321;
        AxisY:   return -64'sd26214;
        default: return 64'sd22938;
      endcase
    endfunction

    function longint wall_hi(int a);
      case (a)
        AxisX:   return 64'sd0;
        AxisY:   return 64'sd26214;
        default: return 64'sd45875;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > VelTop) return VelTop;
      if (v < VelBottom) return VelBottom;
      return v;
    endfunction

    function longint axis_velocity(int a, logic [RawW-1:0] rp, logic [RawW-1:0] rm,
                                   longint p);
      longint lp;
      longint lm;
      longint neg;
      lp = longint'(offset) - longint'(rp);
      lm = longint'(offset) - longint'(rm);
      if (lp > longint'(thr)) begin
        target[a] = p;
        return clip32((lp * longint'(vpc)) >>> 16);
      end
      if (lm > longint'(thr)) begin
        target[a] = p;
        return clip32(-((lm * longint'(vpc)) >>> 16));
      end
      neg = -(longint'(gain) * (p - target[a]));
      return clip32(neg / 64'sd65536);
    endfunction

    function longint clip_wall(int a, longint p, longint v);
      if ((p < wall_lo(a) && v < 0) || (p > wall_hi(a) && v > 0)) return 0;
      return v;
    endfunction

    function void note_sample(pedal_item_t it);
      vel_set_t v;
      longint   p;
      v = '0;
      if (!pose_seen) begin
        for (int a = 0; a < 3; a++) target[a] = longint'($signed(it.pos[a]));
        pose_seen = 1'b1;
      end
      if (mode) begin
        for (int a = 0; a < 3; a++) begin
          p = longint'($signed(it.pos[a]));
          v[a] = VelW'(clip_wall(a, p, axis_velocity(a, it.raw_plus[a],
                                                      it.raw_minus[a], p)));
        end
      end
      due_vel.push_back(v);
    endfunction

    function void check_vel(vel_set_t got);
      vel_set_t want;
      if (due_vel.size() == 0) begin
        $display("%0t: result with no item pending, expected none, actual x=%0d y=%0d z=%0d",
                 $time, $signed(got[AxisX]), $signed(got[AxisY]), $signed(got[AxisZ]));
        errors++;
        return;
      end
      want = due_vel.pop_front();
      for (int a = 0; a < 3; a++) begin
        if (got[a] !== want[a]) begin
          $display("%0t: vel_%c mismatch, expected %0d actual %0d", $time, axis_tag[a],
                   $signed(want[a]), $signed(got[a]));
          errors++;
        end
      end
    endfunction

    function int pending();
      return due_vel.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [RawW-1:0]         raw_x_plus = '0;
  logic [RawW-1:0]         raw_x_minus = '0;
  logic [RawW-1:0]         raw_y_plus = '0;
  logic [RawW-1:0]         raw_y_minus = '0;
  logic [RawW-1:0]         raw_z_plus = '0;
  logic [RawW-1:0]         raw_z_minus = '0;
  logic signed [PosW-1:0]  pos_x = '0;
  logic signed [PosW-1:0]  pos_y = '0;
  logic signed [PosW-1:0]  pos_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VelW-1:0]  vel_x;
  logic signed [VelW-1:0]  vel_y;
  logic signed [VelW-1:0]  vel_z;
  logic                    cfg_we = 1'b0;
  logic [IdxW-1:0]         cfg_index = '0;
  logic [DataW-1:0]        cfg_data = '0;

  velocity_ledger ledger = new();
  int             tx_idle_pct = IdlePct;
  int             rx_idle_pct = IdlePct;
  bit             hold_req = 1'b0;
  int             cycle_count = 0;
  int             last_pos [3] = '{0, 0, 0};

  three_axis_joystick_velocity_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .raw_x_plus  (raw_x_plus),
    .raw_x_minus (raw_x_minus),
    .raw_y_plus  (raw_y_plus),
    .raw_y_minus (raw_y_minus),
    .raw_z_plus  (raw_z_plus),
    .raw_z_minus (raw_z_minus),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .vel_z       (vel_z),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) ledger.check_vel({vel_z, vel_y, vel_x});
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic pedal_item_t make_item(int xp, int xm, int yp, int ym, int zp, int zm,
                                            int px, int py, int pz);
    pedal_item_t it;
    it.raw_plus  = {RawW'(zp), RawW'(yp), RawW'(xp)};
    it.raw_minus = {RawW'(zm), RawW'(ym), RawW'(xm)};
    it.pos       = {PosW'(pz), PosW'(py), PosW'(px)};
    return it;
  endfunction

  function automatic logic [RawW-1:0] random_raw();
    int o;
    int t;
    int lvl;
    int r;
    o = int'(ledger.offset);
    t = int'(ledger.thr);
    case ($urandom_range(9))
      0, 1, 2: lvl = t + 1 + int'($urandom_range(3000));
      3:       lvl = t - 1 + int'($urandom_range(2));
      4, 5, 6: lvl = int'($urandom_range(t)) - 40;
      default: return RawW'($urandom_range(65535));
    endcase
    r = o - lvl;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r[RawW-1:0];
  endfunction

  function automatic logic [PosW-1:0] random_pos(int a);
    int p;
    case ($urandom_range(9))
      0, 1, 2, 3: p = last_pos[a] + int'($urandom_range(4000)) - 2000;
      4, 5, 6: begin
        if ($urandom_range(1) != 0) p = int'(ledger.wall_hi(a));
        else p = int'(ledger.wall_lo(a));
        p = p + int'($urandom_range(4)) - 2;
      end
      default: p = int'($urandom());
    endcase
    last_pos[a] = p;
    return p;
  endfunction

  function automatic pedal_item_t random_item();
    pedal_item_t it;
    for (int a = 0; a < 3; a++) begin
      it.raw_plus[a]  = random_raw();
      it.raw_minus[a] = random_raw();
      it.pos[a]       = random_pos(a);
    end
    return it;
  endfunction

  task automatic send_sample(input pedal_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    raw_x_plus  = it.raw_plus[AxisX];
    raw_x_minus = it.raw_minus[AxisX];
    raw_y_plus  = it.raw_plus[AxisY];
    raw_y_minus = it.raw_minus[AxisY];
    raw_z_plus  = it.raw_plus[AxisZ];
    raw_z_minus = it.raw_minus[AxisZ];
    pos_x       = it.pos[AxisX];
    pos_y       = it.pos[AxisY];
    pos_z       = it.pos[AxisZ];
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_sample(it);
    @(negedge clk);
  endtask

  task automatic put_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    ledger.set_reg(idx, data);
  endtask

  task automatic apply_settings(input logic m, input logic [RawW-1:0] o,
                                input logic [RawW-1:0] t, input logic [VpcW-1:0] v,
                                input logic [GainW-1:0] g);
    put_reg(REG_CONTROL_MODE, {31'($urandom()), m});
    put_reg(REG_ADC_ZERO_OFFSET, {16'($urandom()), o});
    put_reg(REG_PRESS_THRESHOLD, {16'($urandom()), t});
    put_reg(REG_VELOCITY_PER_COUNT, v);
    put_reg(REG_CONVERGENCE_GAIN, {8'($urandom()), g});
  endtask

  task automatic apply_random_settings();
    logic [RawW-1:0] o;
    logic [RawW-1:0] t;
    if ($urandom_range(3) == 0) o = RawW'($urandom_range(65535));
    else o = RawW'($urandom_range(36000, 34000));
    if ($urandom_range(1) != 0) t = RawW'($urandom_range(2000));
    else t = RawW'($urandom_range(65535));
    apply_settings($urandom_range(9) != 0, o, t, $urandom(), GainW'($urandom()));
    put_reg(IdxW'($urandom_range(SpareIdxLast, SpareIdxFirst)), $urandom());
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: off mode, first item loads the targets
    send_sample(make_item(0, 0, 0, 0, 0, 0, 100, 200, 30000));
    send_sample(make_item(65535, 65535, 0, 65535, 0, 65535, -5000, 7000, 40000));
    settle();

    apply_settings(1'b1, 16'd35000, 16'd1000, 32'h0010_0000, 24'h01_0000);
    send_sample(make_item(35000, 35000, 35000, 35000, 35000, 35000, 100, 200, 30000));
    send_sample(make_item(34000, 34000, 34000, 34000, 34000, 34000, 600, -300, 31000));
    send_sample(make_item(33999, 35000, 33999, 35000, 33999, 35000, -100, 0, 30000));
    send_sample(make_item(35000, 20000, 35000, 20000, 35000, 20000, -200, 100, 32000));
    send_sample(make_item(0, 0, 0, 0, 0, 0, -1, 1, 30000));
    send_sample(make_item(65535, 65535, 65535, 65535, 65535, 65535, 0, 0, 30000));
    send_sample(make_item(35000, 0, 35000, 0, 35000, 0, -39322, -26215, 22937));
    send_sample(make_item(35000, 0, 35000, 0, 35000, 0, -39321, -26214, 22938));
    send_sample(make_item(0, 35000, 0, 35000, 0, 35000, 1, 26215, 45876));
    send_sample(make_item(0, 35000, 0, 35000, 0, 35000, 0, 26214, 45875));
    settle();

    apply_settings(1'b1, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_sample(make_item(0, 0, 0, 0, 0, 0, PosMin, PosMin, PosMin));
    send_sample(make_item(65535, 0, 65535, 0, 65535, 0, PosMax, PosMax, PosMax));
    send_sample(make_item(65535, 65535, 65535, 65535, 65535, 65535, PosMin, PosMin, PosMin));
    send_sample(make_item(0, 65535, 0, 65535, 0, 65535, PosMin, PosMin, PosMin));
    send_sample(make_item(65535, 65535, 65535, 65535, 65535, 65535, PosMax, PosMax, PosMax));
    settle();

    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: apply_settings(1'b1, 16'h0000, 16'h0000, $urandom(), GainW'($urandom()));
        1: apply_settings(1'b1, 16'hFFFF, 16'hFFFF, $urandom(), GainW'($urandom()));
        2: apply_settings(1'b0, 16'd35000, RawW'($urandom_range(2000)), $urandom(),
                          GainW'($urandom()));
        default: apply_random_settings();
      endcase
      tx_idle_pct = (phase == 3) ? 0 : IdlePct;
      rx_idle_pct = (phase == 3) ? 0 : IdlePct;
      if (phase == 4) hold_req = 1'b1;
      repeat (PhaseItems) send_sample(random_item());
      settle();
    end

    if (ledger.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/tajv_pkg.sv
sv/tajv_cfg.sv
sv/tajv_lane.sv
sv/three_axis_joystick_velocity_top.sv
tb/three_axis_joystick_velocity_top_tb.sv
